/* hdl/grid_astar_path_search_defines.svh */
// ----------------------------------------------------------------------------
// Grid A* path search assertion macros
// Shared assertion forms, clocked on clk with an asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef GRID_ASTAR_PATH_SEARCH_DEFINES_SVH
`define GRID_ASTAR_PATH_SEARCH_DEFINES_SVH

// same-cycle implication
`define GASP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GASP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/gasp_pkg.sv */
// ----------------------------------------------------------------------------
// Grid A* path search package
// Shared constants, cell codes, register indexes and small helper functions.
// ----------------------------------------------------------------------------
package gasp_pkg;

	localparam int MAX_SIDE = 8;
	localparam int NCELLS   = MAX_SIDE * MAX_SIDE;
	localparam int IDX_W    = $clog2(NCELLS);
	localparam int RC_W     = $clog2(MAX_SIDE);
	localparam int SIDE_W   = 4;
	localparam int COST_W   = 10;
	localparam int G_W      = 16;
	localparam int F_W      = 17;
	localparam int H_W      = 14;

	typedef enum logic [1:0] {
		CELL_EMPTY = 2'd0,
		CELL_BLOCK = 2'd1,
		CELL_START = 2'd2,
		CELL_DEST  = 2'd3
	} cell_kind_t;

	typedef enum logic [1:0] {
		REG_GRID_SIDE      = 2'd0,
		REG_STRAIGHT_COST  = 2'd1,
		REG_DIAGONAL_COST  = 2'd2,
		REG_HEURISTIC_UNIT = 2'd3
	} reg_index_t;

	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_SEARCH = 1'b1;

	// neighbor order: left, right, up, down, then the diagonals
	function automatic logic signed [1:0] step_row(input logic [2:0] d);
		logic signed [1:0] v;
		case (d)
			3'd2, 3'd5, 3'd6: v = -2'sd1;
			3'd3, 3'd4, 3'd7: v = 2'sd1;
			default:          v = 2'sd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [1:0] step_col(input logic [2:0] d);
		logic signed [1:0] v;
		case (d)
			3'd0, 3'd4, 3'd5: v = -2'sd1;
			3'd1, 3'd6, 3'd7: v = 2'sd1;
			default:          v = 2'sd0;
		endcase
		return v;
	endfunction

	function automatic logic [IDX_W-1:0] cell_at(input logic [RC_W-1:0] r,
		input logic [RC_W-1:0] c, input logic [SIDE_W-1:0] side);
		logic [IDX_W:0] p;
		p = (IDX_W+1)'(r) * (IDX_W+1)'(side) + (IDX_W+1)'(c);
		return p[IDX_W-1:0];
	endfunction

	function automatic logic [H_W-1:0] heur(input logic [RC_W-1:0] r,
		input logic [RC_W-1:0] c, input logic [RC_W-1:0] dr,
		input logic [RC_W-1:0] dc, input logic [COST_W-1:0] unit_w);
		logic [RC_W-1:0] a;
		logic [RC_W-1:0] b;
		logic [RC_W:0]   s;
		a = (r > dr) ? r - dr : dr - r;
		b = (c > dc) ? c - dc : dc - c;
		s = (RC_W+1)'(a) + (RC_W+1)'(b);
		return H_W'(s) * H_W'(unit_w);
	endfunction

endpackage

/* hdl/gasp_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gasp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hdl/grid_astar_path_search.sv */
// ----------------------------------------------------------------------------
// Grid A* path search
// 8-connected A* over a square grid of up to 8x8 cells, path emitted start first.
// ----------------------------------------------------------------------------
// A load transaction writes one cell type and leaves busy low. A search
// transaction raises busy until its last result. Each node pop scans the open
// set through the estimate RAM, reads g of the node and walks 8 neighbors
// through the single cell-type read port, skipping a neighbor off the grid and
// otherwise reading the neighbor and both corner cells. A full 8x8 search pops
// at most 64 nodes; a scan for the start and destination cells comes first, and
// the path is traced back through the parent RAM and then read out. Results
// come out on result_valid for one cycle each and cannot be stalled: the
// receiver must take every one.
module grid_astar_path_search (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [5:0]  cell_index,
	input  logic [1:0]  cell_type,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic        result_valid,
	output logic        found,
	output logic [5:0]  path_index,
	output logic        last
);

	localparam int IW = gasp_pkg::IDX_W;
	localparam int RW = gasp_pkg::RC_W;

	typedef enum logic [15:0] {
		S_IDLE   = 16'h0001,
		S_FIND   = 16'h0002,
		S_INIT   = 16'h0004,
		S_MIN    = 16'h0008,
		S_GBEST  = 16'h0010,
		S_GBEST2 = 16'h0020,
		S_NB_CHK = 16'h0040,
		S_NB_RA  = 16'h0080,
		S_NB_RB  = 16'h0100,
		S_NB_RC  = 16'h0200,
		S_NB_UPD = 16'h0400,
		S_BT     = 16'h0800,
		S_BT2    = 16'h1000,
		S_OUT_RD = 16'h2000,
		S_OUT_EM = 16'h4000,
		S_FAIL   = 16'h8000
	} state_t;

	state_t state_q;

	logic [gasp_pkg::SIDE_W-1:0] grid_side_q;
	logic [gasp_pkg::COST_W-1:0] straight_q;
	logic [gasp_pkg::COST_W-1:0] diagonal_q;
	logic [gasp_pkg::COST_W-1:0] hunit_q;

	logic [gasp_pkg::NCELLS-1:0] open_q;
	logic [gasp_pkg::NCELLS-1:0] closed_q;

	logic [IW-1:0] cnt_q;
	logic [RW-1:0] row_q, col_q;
	logic          iss_q;
	logic          vld_s1;
	logic [IW-1:0] idx_s1;
	logic [RW-1:0] row_s1, col_s1;

	logic          st_ok_q, ds_ok_q;
	logic [IW-1:0] st_idx_q, ds_idx_q;
	logic [RW-1:0] st_r_q, st_c_q, ds_r_q, ds_c_q;

	logic                     have_q;
	logic [gasp_pkg::F_W-1:0] bf_q;
	logic [IW-1:0]            best_q;
	logic [RW-1:0]            best_r_q, best_c_q;

	logic [gasp_pkg::G_W-1:0] gb_q;
	logic [2:0]               d_q;
	logic [IW-1:0]            ni_q, ca_q, cb_q;
	logic [gasp_pkg::G_W-1:0] g_q;
	logic [gasp_pkg::H_W-1:0] h_q;
	logic                     blk_q;

	logic [IW-1:0] cur_q;
	logic [IW-1:0] len_q;
	logic [IW-1:0] ptr_q;

	logic          rv_q, found_q, last_q;
	logic [IW-1:0] path_q;

	// side clamp and scan bounds
	logic [gasp_pkg::SIDE_W-1:0] side;
	logic [RW-1:0]               side_m1;
	logic [IW:0]                 ncell;
	logic [IW-1:0]               last_idx;

	always_comb begin
		if (grid_side_q < 4'd2) begin
			side = 4'd2;
		end else if (grid_side_q > gasp_pkg::SIDE_W'(gasp_pkg::MAX_SIDE)) begin
			side = gasp_pkg::SIDE_W'(gasp_pkg::MAX_SIDE);
		end else begin
			side = grid_side_q;
		end
		side_m1  = RW'(side - 4'd1);
		ncell    = (IW+1)'(side) * (IW+1)'(side);
		last_idx = IW'(ncell - (IW+1)'(1));
	end

	// RAMs
	logic                     kind_we;
	logic [IW-1:0]            kind_raddr;
	logic [1:0]               kind_rd;
	logic                     cost_we;
	logic [IW-1:0]            cost_waddr, cost_raddr;
	logic [gasp_pkg::G_W-1:0] cost_wdata, cost_rd;
	logic [gasp_pkg::F_W-1:0] tot_wdata, tot_rd;
	logic                     par_we;
	logic [IW-1:0]            par_rd;
	logic                     chn_we;
	logic [IW-1:0]            chn_rd;

	logic accept;
	assign accept  = start && (state_q == S_IDLE);
	assign kind_we = accept && (kind == gasp_pkg::KIND_LOAD);

	always_comb begin
		unique case (state_q)
			S_NB_RA: kind_raddr = ni_q;
			S_NB_RB: kind_raddr = ca_q;
			S_NB_RC: kind_raddr = cb_q;
			default: kind_raddr = cnt_q;
		endcase
	end

	// neighbor update decision
	logic upd;
	logic blocked;
	assign blocked = blk_q || (kind_rd == gasp_pkg::CELL_BLOCK) || closed_q[ni_q];
	assign upd     = (state_q == S_NB_UPD) && !blocked && (!open_q[ni_q] || (cost_rd > g_q));

	logic [gasp_pkg::H_W-1:0] h_start;
	assign h_start = gasp_pkg::heur(st_r_q, st_c_q, ds_r_q, ds_c_q, hunit_q);

	always_comb begin
		cost_we    = upd || (state_q == S_INIT);
		cost_waddr = (state_q == S_INIT) ? st_idx_q : ni_q;
		cost_wdata = (state_q == S_INIT) ? '0 : g_q;
		tot_wdata  = (state_q == S_INIT) ? gasp_pkg::F_W'(h_start)
			: gasp_pkg::F_W'(g_q) + gasp_pkg::F_W'(h_q);
		cost_raddr = (state_q == S_GBEST) ? best_q : ni_q;
	end

	assign par_we = upd;
	assign chn_we = (state_q == S_BT);

	gasp_ram #(.WIDTH(2), .DEPTH(gasp_pkg::NCELLS)) u_kind_ram (
		.clk(clk), .we(kind_we), .waddr(cell_index), .wdata(cell_type),
		.raddr(kind_raddr), .rdata(kind_rd)
	);

	gasp_ram #(.WIDTH(gasp_pkg::G_W), .DEPTH(gasp_pkg::NCELLS)) u_cost_ram (
		.clk(clk), .we(cost_we), .waddr(cost_waddr), .wdata(cost_wdata),
		.raddr(cost_raddr), .rdata(cost_rd)
	);

	gasp_ram #(.WIDTH(gasp_pkg::F_W), .DEPTH(gasp_pkg::NCELLS)) u_tot_ram (
		.clk(clk), .we(cost_we), .waddr(cost_waddr), .wdata(tot_wdata),
		.raddr(cnt_q), .rdata(tot_rd)
	);

	gasp_ram #(.WIDTH(IW), .DEPTH(gasp_pkg::NCELLS)) u_par_ram (
		.clk(clk), .we(par_we), .waddr(ni_q), .wdata(best_q),
		.raddr(cur_q), .rdata(par_rd)
	);

	gasp_ram #(.WIDTH(IW), .DEPTH(gasp_pkg::NCELLS)) u_chain_ram (
		.clk(clk), .we(chn_we), .waddr(len_q), .wdata(cur_q),
		.raddr(ptr_q), .rdata(chn_rd)
	);

	// neighbor geometry for the current direction
	logic signed [RW+1:0] nr, nc;
	logic                 in_grid;
	logic [RW-1:0]        nr_u, nc_u;
	logic [gasp_pkg::COST_W-1:0] step_cost;
	logic [gasp_pkg::G_W:0]      g_sum;

	always_comb begin
		nr = $signed({2'b00, best_r_q}) + (RW+2)'(gasp_pkg::step_row(d_q));
		nc = $signed({2'b00, best_c_q}) + (RW+2)'(gasp_pkg::step_col(d_q));
		in_grid = (nr >= 0) && (nr < $signed({1'b0, side})) &&
			(nc >= 0) && (nc < $signed({1'b0, side}));
		nr_u = nr[RW-1:0];
		nc_u = nc[RW-1:0];
		step_cost = (d_q < 3'd4) ? straight_q : diagonal_q;
		g_sum = (gasp_pkg::G_W+1)'(gb_q) + (gasp_pkg::G_W+1)'(step_cost);
	end

	logic scan_done;
	assign scan_done = !iss_q && !vld_s1;

	// APB
	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_comb begin
		unique case (gasp_pkg::reg_index_t'(paddr[3:2]))
			gasp_pkg::REG_GRID_SIDE:      prdata = 32'(grid_side_q);
			gasp_pkg::REG_STRAIGHT_COST:  prdata = 32'(straight_q);
			gasp_pkg::REG_DIAGONAL_COST:  prdata = 32'(diagonal_q);
			gasp_pkg::REG_HEURISTIC_UNIT: prdata = 32'(hunit_q);
			default:                      prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_side_q <= 4'd8;
			straight_q  <= 10'd256;
			diagonal_q  <= 10'd362;
			hunit_q     <= 10'd256;
		end else if (cfg_wr) begin
			unique case (gasp_pkg::reg_index_t'(paddr[3:2]))
				gasp_pkg::REG_GRID_SIDE:      grid_side_q <= pwdata[3:0];
				gasp_pkg::REG_STRAIGHT_COST:  straight_q  <= pwdata[9:0];
				gasp_pkg::REG_DIAGONAL_COST:  diagonal_q  <= pwdata[9:0];
				gasp_pkg::REG_HEURISTIC_UNIT: hunit_q     <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	// scan pipeline: issue address, read data lands in stage 1 on the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q  <= 1'b0;
			vld_s1 <= 1'b0;
		end else if (((state_q == S_IDLE) && accept && (kind == gasp_pkg::KIND_SEARCH)) ||
			((state_q == S_INIT) || (state_q == S_GBEST2 && 1'b0)) ||
			(state_q == S_NB_UPD && d_q == 3'd7) ||
			(state_q == S_NB_CHK && !in_grid && d_q == 3'd7)) begin
			iss_q  <= 1'b1;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= iss_q;
			if (iss_q && cnt_q == last_idx) begin
				iss_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (iss_q) begin
			idx_s1 <= cnt_q;
			row_s1 <= row_q;
			col_s1 <= col_q;
			cnt_q  <= cnt_q + IW'(1);
			if (col_q == side_m1) begin
				col_q <= '0;
				row_q <= row_q + RW'(1);
			end else begin
				col_q <= col_q + RW'(1);
			end
		end else begin
			cnt_q <= '0;
			row_q <= '0;
			col_q <= '0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rv_q    <= 1'b0;
		end else begin
			rv_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && kind == gasp_pkg::KIND_SEARCH) begin
						state_q <= S_FIND;
					end
				end
				S_FIND: begin
					if (scan_done) begin
						state_q <= (st_ok_q && ds_ok_q) ? S_INIT : S_FAIL;
					end
				end
				S_INIT: state_q <= S_MIN;
				S_MIN: begin
					if (scan_done) begin
						if (!have_q) begin
							state_q <= S_FAIL;
						end else if (best_q == ds_idx_q) begin
							state_q <= S_BT;
						end else begin
							state_q <= S_GBEST;
						end
					end
				end
				S_GBEST:  state_q <= S_GBEST2;
				S_GBEST2: state_q <= S_NB_CHK;
				S_NB_CHK: begin
					if (in_grid) begin
						state_q <= S_NB_RA;
					end else if (d_q == 3'd7) begin
						state_q <= S_MIN;
					end
				end
				S_NB_RA: state_q <= S_NB_RB;
				S_NB_RB: state_q <= S_NB_RC;
				S_NB_RC: state_q <= S_NB_UPD;
				S_NB_UPD: state_q <= (d_q == 3'd7) ? S_MIN : S_NB_CHK;
				S_BT: state_q <= (cur_q == st_idx_q) ? S_OUT_RD : S_BT2;
				S_BT2: state_q <= S_BT;
				S_OUT_RD: state_q <= S_OUT_EM;
				S_OUT_EM: begin
					rv_q    <= 1'b1;
					state_q <= (ptr_q == '0) ? S_IDLE : S_OUT_RD;
				end
				S_FAIL: begin
					rv_q    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				open_q   <= '0;
				closed_q <= '0;
				st_ok_q  <= 1'b0;
				ds_ok_q  <= 1'b0;
			end
			S_FIND: begin
				if (vld_s1) begin
					if (!st_ok_q && kind_rd == gasp_pkg::CELL_START) begin
						st_ok_q  <= 1'b1;
						st_idx_q <= idx_s1;
						st_r_q   <= row_s1;
						st_c_q   <= col_s1;
					end
					if (!ds_ok_q && kind_rd == gasp_pkg::CELL_DEST) begin
						ds_ok_q  <= 1'b1;
						ds_idx_q <= idx_s1;
						ds_r_q   <= row_s1;
						ds_c_q   <= col_s1;
					end
				end
			end
			S_INIT: begin
				open_q[st_idx_q] <= 1'b1;
				have_q           <= 1'b0;
			end
			S_MIN: begin
				if (vld_s1 && open_q[idx_s1] && (!have_q || tot_rd < bf_q)) begin
					have_q   <= 1'b1;
					bf_q     <= tot_rd;
					best_q   <= idx_s1;
					best_r_q <= row_s1;
					best_c_q <= col_s1;
				end
				if (scan_done && have_q) begin
					open_q[best_q]   <= 1'b0;
					closed_q[best_q] <= 1'b1;
					cur_q            <= ds_idx_q;
					len_q            <= '0;
				end
			end
			S_GBEST2: begin
				gb_q <= cost_rd;
				d_q  <= '0;
			end
			S_NB_CHK: begin
				ni_q  <= gasp_pkg::cell_at(nr_u, nc_u, side);
				ca_q  <= gasp_pkg::cell_at(nr_u, best_c_q, side);
				cb_q  <= gasp_pkg::cell_at(best_r_q, nc_u, side);
				g_q   <= g_sum[gasp_pkg::G_W] ? '1 : g_sum[gasp_pkg::G_W-1:0];
				h_q   <= gasp_pkg::heur(nr_u, nc_u, ds_r_q, ds_c_q, hunit_q);
				if (!in_grid) begin
					if (d_q == 3'd7) begin
						have_q <= 1'b0;
					end
					d_q <= d_q + 3'd1;
				end
			end
			S_NB_RB: blk_q <= (kind_rd == gasp_pkg::CELL_BLOCK);
			S_NB_RC: blk_q <= blk_q || (kind_rd == gasp_pkg::CELL_BLOCK);
			S_NB_UPD: begin
				if (upd) begin
					open_q[ni_q] <= 1'b1;
				end
				if (d_q == 3'd7) begin
					have_q <= 1'b0;
				end
				d_q <= d_q + 3'd1;
			end
			S_BT: begin
				ptr_q <= len_q;
			end
			S_BT2: begin
				cur_q <= par_rd;
				len_q <= len_q + IW'(1);
			end
			S_OUT_EM: begin
				found_q <= 1'b1;
				path_q  <= chn_rd;
				last_q  <= (ptr_q == '0);
				ptr_q   <= ptr_q - IW'(1);
			end
			S_FAIL: begin
				found_q <= 1'b0;
				path_q  <= '0;
				last_q  <= 1'b1;
			end
			default: ;
		endcase
	end

	assign busy         = (state_q != S_IDLE);
	assign result_valid = rv_q;
	assign found        = found_q;
	assign path_index   = path_q;
	assign last         = last_q;

endmodule

/* hdl/gasp_chk.sv */
// ----------------------------------------------------------------------------
// Grid A* path search port checker
// Port-level properties of the search block, bound to the top level.
// ----------------------------------------------------------------------------
`include "grid_astar_path_search_defines.svh"

module gasp_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       kind,
	input logic       result_valid,
	input logic       found,
	input logic [5:0] path_index,
	input logic       last
);

	`GASP_ASSERT_NEXT(a_last_ends_run, result_valid && last, !result_valid, "result after last")
	`GASP_ASSERT_NOW(a_fail_is_last, result_valid && !found, last, "failure not last")
	`GASP_ASSERT_NOW(a_fail_index, result_valid && !found, path_index == 6'd0, "failure index")
	`GASP_ASSERT_NEXT(a_search_busy, start && !busy && kind, busy, "search not started")
	`GASP_ASSERT_NEXT(a_load_quiet, start && !busy && !kind, !busy && !result_valid, "load not quiet")

endmodule

bind grid_astar_path_search gasp_chk u_gasp_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
	.result_valid(result_valid), .found(found), .path_index(path_index), .last(last)
);
